// ----- design/mqrr_pkg.sv -----
// Package for the round-robin multi-queue with limits.
// Holds item and result structs, action and status codes, controller states.
package mqrr_pkg;

  localparam int NUM_QUEUES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_DRAIN = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [1:0] REG_BYTE_LIMIT  = 2'd0;
  localparam logic [1:0] REG_COUNT_LIMIT = 2'd1;
  localparam logic [1:0] REG_MEMBER_MASK = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  queue_id;
    logic [31:0] payload;
    logic [15:0] item_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  source_queue;
    logic [31:0] item_payload;
    logic [15:0] item_size;
    logic        last;
    logic [4:0]  run_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_READ, S_SHOW, S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic decide;   // evaluate queue state, pick queue
    logic rd_issue; // issue store read at head, pop
    logic capture;  // register result from store data
    logic resp;     // register single result with no read
    logic out_clr;  // result taken
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;  // item needs a store read
    logic more;     // more items left in drain run
  } sts_t;

endpackage

// ----- design/mqrr_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module mqrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/mqrr_ctrl.sv -----
// Controller state machine for the multi-queue.
// Depends on mqrr_pkg.
module mqrr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_fire,
  input  mqrr_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output mqrr_pkg::cmd_t cmd
);
  mqrr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqrr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      mqrr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_nxt = mqrr_pkg::S_DECIDE;
      end
      mqrr_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = mqrr_pkg::S_READ;
      end
      mqrr_pkg::S_READ: begin
        if (sts.is_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = mqrr_pkg::S_SHOW;
        end else begin
          cmd.resp  = 1'b1;
          state_nxt = mqrr_pkg::S_RESP;
        end
      end
      mqrr_pkg::S_SHOW: begin
        // read data arrives; register it as the result
        cmd.capture = 1'b1;
        state_nxt   = mqrr_pkg::S_RESP;
      end
      mqrr_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (out_fire) begin
          cmd.out_clr = 1'b1;
          state_nxt   = sts.more ? mqrr_pkg::S_READ : mqrr_pkg::S_IDLE;
        end
      end
      default: state_nxt = mqrr_pkg::S_IDLE;
    endcase
  end

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result shown");
  a_show_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> cmd.capture) else $error("read not captured");
  a_load_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.decide) else $error("decide missing");
endmodule

// ----- design/mqrr_dp.sv -----
// Datapath: per-queue counters, limits, round-robin pick, item stores.
// Depends on mqrr_pkg and mqrr_ram.
module mqrr_dp #(
  parameter int NUM_QUEUES   = mqrr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH  = mqrr_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = mqrr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mqrr_pkg::cmd_t     cmd,
  input  mqrr_pkg::in_item_t in_item,
  input  logic [23:0]        byte_limit,
  input  logic [4:0]         count_limit,
  input  logic [7:0]         member_mask,
  output mqrr_pkg::sts_t     sts,
  output mqrr_pkg::out_item_t out_item
);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = HW + 17;
  localparam int AW = QW + HW;

  logic [HW-1:0] head_r  [NUM_QUEUES];
  logic [CW-1:0] count_r [NUM_QUEUES];
  logic [BW-1:0] bytes_r [NUM_QUEUES];
  logic [QW-1:0] next_r;

  mqrr_pkg::in_item_t item_r;
  logic [QW-1:0] q_r;
  logic          isrd_r, drain_r;
  logic [CW-1:0] run_r, left_r;
  mqrr_pkg::out_item_t out_r;

  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic [15:0]             size_rd;

  // round-robin pick over members
  logic          found;
  logic [QW-1:0] pick;
  always_comb begin
    int c;
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      c = int'(next_r) + i;
      if (c >= NUM_QUEUES) c = c - NUM_QUEUES;
      if (!found && c < 8 && member_mask[3'(c)] && count_r[QW'(c)] != '0) begin
        found = 1'b1;
        pick  = QW'(c);
      end
    end
  end

  // write decision for the named queue
  logic          qok;
  logic [QW-1:0] qn;
  logic          refuse;
  logic [31:0]   btot;
  always_comb begin
    qok  = (32'(item_r.queue_id) < NUM_QUEUES);
    qn   = QW'(item_r.queue_id);
    btot = 32'(bytes_r[qn]) + 32'(item_r.item_bytes);
    if (!qok) refuse = 1'b1;
    else if (byte_limit != '0 && btot > 32'(byte_limit)) refuse = 1'b1;
    else if (count_limit != '0 && 6'(count_r[qn]) + 6'd1 > {1'b0, count_limit})
      refuse = 1'b1;
    else refuse = (32'(count_r[qn]) >= 32'(QUEUE_DEPTH));
  end

  logic          do_wr;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] tail;
  logic [HW:0]   tail_sum;
  assign tail_sum = {1'b0, head_r[qn]} + (HW+1)'(count_r[qn]);
  // wrap past the end of the queue's slots
  assign tail  = (32'(tail_sum) >= QUEUE_DEPTH) ? HW'(32'(tail_sum) - QUEUE_DEPTH) :
                                                  HW'(tail_sum);
  assign do_wr = cmd.decide && item_r.action == mqrr_pkg::ACT_WRITE && !refuse;
  assign waddr = {qn, tail};
  assign raddr = {q_r, head_r[q_r]};

  mqrr_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(2**AW)) u_pay (
    .clk(clk), .we(do_wr), .waddr(waddr), .wdata(PAYLOAD_BITS'(item_r.payload)),
    .raddr(raddr), .rdata(pay_rd));
  mqrr_ram #(.WIDTH(16), .DEPTH(2**AW)) u_size (
    .clk(clk), .we(do_wr), .waddr(waddr), .wdata(item_r.item_bytes),
    .raddr(raddr), .rdata(size_rd));

  logic [1:0] resp_st;
  logic [2:0] resp_q;

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.decide) begin
      drain_r <= item_r.action == mqrr_pkg::ACT_DRAIN;
      unique case (item_r.action)
        mqrr_pkg::ACT_WRITE: begin
          isrd_r  <= 1'b0;
          resp_st <= refuse ? mqrr_pkg::ST_REFUSE : mqrr_pkg::ST_OK;
          resp_q  <= item_r.queue_id;
        end
        mqrr_pkg::ACT_READ: begin
          q_r     <= qn;
          isrd_r  <= qok && count_r[qn] != '0;
          run_r   <= CW'(1);
          left_r  <= CW'(1);
          resp_st <= mqrr_pkg::ST_EMPTY;
          resp_q  <= item_r.queue_id;
        end
        default: begin
          q_r     <= pick;
          isrd_r  <= found;
          run_r   <= (item_r.action == mqrr_pkg::ACT_DRAIN) ? count_r[pick] : CW'(1);
          left_r  <= (item_r.action == mqrr_pkg::ACT_DRAIN) ? count_r[pick] : CW'(1);
          resp_st <= mqrr_pkg::ST_EMPTY;
          resp_q  <= '0;
        end
      endcase
    end
    if (cmd.rd_issue) left_r <= left_r - CW'(1);
    if (cmd.resp) begin
      out_r <= '{status: resp_st, source_queue: resp_q, item_payload: '0,
                 item_size: '0, last: 1'b1, run_count: '0};
    end
    if (cmd.capture) begin
      out_r <= '{status: mqrr_pkg::ST_OK, source_queue: 3'(q_r),
                 item_payload: 32'(pay_rd), item_size: size_rd,
                 last: (left_r == '0), run_count: 5'(run_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0; count_r[i] <= '0; bytes_r[i] <= '0;
      end
      next_r <= '0;
    end else begin
      if (do_wr) begin
        count_r[qn] <= count_r[qn] + CW'(1);
        bytes_r[qn] <= bytes_r[qn] + BW'(item_r.item_bytes);
      end
      if (cmd.decide && item_r.action[1] && found) begin
        next_r <= (32'(pick) + 1 >= NUM_QUEUES) ? '0 : QW'(32'(pick) + 1);
      end
      if (cmd.rd_issue) begin
        head_r[q_r]  <= (32'(head_r[q_r]) + 1 >= QUEUE_DEPTH) ? '0 : head_r[q_r] + HW'(1);
        count_r[q_r] <= count_r[q_r] - CW'(1);
      end
      // size arrives in the cycle after the pop
      if (cmd.capture) begin
        if (drain_r && left_r == '0) begin
          head_r[q_r]  <= '0;
          bytes_r[q_r] <= '0;
        end else begin
          bytes_r[q_r] <= (bytes_r[q_r] >= BW'(size_rd)) ?
                          bytes_r[q_r] - BW'(size_rd) : '0;
        end
      end
    end
  end

  assign sts.is_read = isrd_r;
  assign sts.more    = isrd_r && left_r != '0;
  assign out_item    = out_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> count_r[q_r] != '0) else $error("pop from empty queue");
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> left_r != '0) else $error("run overrun");
  a_no_wr_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_wr && cmd.rd_issue)) else $error("write during pop");
endmodule

// ----- design/multi_queue_round_robin_with_limits.sv -----
// Top level of the round-robin multi-queue with limits.
// Depends on mqrr_pkg, mqrr_ctrl, mqrr_dp, mqrr_ram.
//
//  channel  | handshake              | payload
//  in_      | in_valid / in_ready    | in_item  (mqrr_pkg::in_item_t)
//  out_     | out_valid / out_ready  | out_item (mqrr_pkg::out_item_t)
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Write or empty read: accept, decide, register result. Pop: accept, decide,
// store read, capture registered read data; drain repeats per result taken.
// The next item is taken once the last result is taken.
// Reset is synchronous; counters and pointer clear, stores are not cleared.
// A stalled out_ready holds the result and the controller.
module multi_queue_round_robin_with_limits #(
  parameter int NUM_QUEUES   = mqrr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH  = mqrr_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = mqrr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqrr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mqrr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  logic [23:0] byte_limit_r;
  logic [4:0]  count_limit_r;
  logic [7:0]  member_mask_r;
  mqrr_pkg::cmd_t cmd;
  mqrr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= '0; count_limit_r <= '0; member_mask_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == mqrr_pkg::REG_BYTE_LIMIT)  byte_limit_r  <= cfg_data;
      if (cfg_index == mqrr_pkg::REG_COUNT_LIMIT) count_limit_r <= cfg_data[4:0];
      if (cfg_index == mqrr_pkg::REG_MEMBER_MASK) member_mask_r <= cfg_data[7:0];
    end
  end

  mqrr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready), .sts(sts),
    .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd));

  mqrr_dp #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH),
            .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
    .byte_limit(byte_limit_r), .count_limit(count_limit_r),
    .member_mask(member_mask_r), .sts(sts), .out_item(out_item));
endmodule
